FILE: rtl/wrle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrle_pkg: shared types and constants of the word run-length encoder
// Holds the command that the front end hands through the queue to the back
// end, and the fixed encoding constants.
// ----------------------------------------------------------------------------
package wrle_pkg;

  localparam int unsigned WordW = 64;

  // Marker word that opens an encoded run
  localparam logic [WordW-1:0] RunMarker = 64'hFEFE_FEFE_FEFE_FEFE;

  // Runs longer than this are sent as marker, count, word
  localparam logic [WordW-1:0] RunMinMarked = 64'd2;

  // Flush work for one input item: a pending run, then an optional single word
  typedef struct packed {
    logic [WordW-1:0] run_word;
    logic [WordW-1:0] run_count;
    logic             has_extra;
    logic [WordW-1:0] extra_word;
    logic             last;
  } wrle_cmd_t;

endpackage

FILE: rtl/wrle_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrle_front: input classification and run tracking
// Compares each word with the previous one, keeps the repeat count and
// queues a command whenever the item causes output words.
// ----------------------------------------------------------------------------
module wrle_front
  import wrle_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [WordW-1:0] word,
  input  logic             last,
  output logic             push,
  output wrle_cmd_t        cmd
);

  logic [WordW-1:0] prev_r, prev_nxt;
  logic             have_r, have_nxt;
  logic [WordW-1:0] count_r, count_nxt;

  logic is_eq;
  logic cnt_max;

  assign is_eq   = have_r && (word == prev_r);
  assign cnt_max = &count_r;

  always_comb begin
    prev_nxt       = prev_r;
    have_nxt       = have_r;
    count_nxt      = count_r;
    push           = 1'b0;
    cmd.run_word   = prev_r;
    cmd.run_count  = count_r;
    cmd.has_extra  = 1'b0;
    cmd.extra_word = prev_r;
    cmd.last       = last;
    if (accept) begin
      if (is_eq) begin
        if (cnt_max) begin
          // flush the full run, then a new run of one; flush that too on last
          push          = 1'b1;
          cmd.has_extra = last;
          count_nxt     = {{(WordW-1){1'b0}}, 1'b1};
        end else begin
          count_nxt     = count_r + 1'b1;
          cmd.run_count = count_r + 1'b1;
          push          = last;
        end
      end else begin
        push           = 1'b1;
        cmd.has_extra  = 1'b1;
        cmd.extra_word = word;
        prev_nxt       = word;
        have_nxt       = 1'b1;
        count_nxt      = '0;
      end
      if (last) begin
        prev_nxt  = '0;
        have_nxt  = 1'b0;
        count_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      have_r  <= 1'b0;
      count_r <= '0;
    end else begin
      prev_r  <= prev_nxt;
      have_r  <= have_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

FILE: rtl/wrle_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrle_fifo: command queue between front and back end
// Small register queue of flush commands; first-word fall-through read.
// ----------------------------------------------------------------------------
module wrle_fifo
  import wrle_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  wrle_cmd_t push_cmd,
  input  logic      pop,
  output logic      full,
  output logic      empty,
  output wrle_cmd_t head
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  wrle_cmd_t       mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: rtl/wrle_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrle_back: output word sequencer
// Expands one queued command into its output words, one per cycle while the
// output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module wrle_back
  import wrle_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  input  wrle_cmd_t        cmd,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [WordW-1:0] out_tdata,
  output logic             out_tuser,
  output logic             out_tlast
);

  logic [1:0]       phase_r, phase_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [WordW-1:0] out_data_r;
  logic             out_user_r;
  logic             out_last_r;

  logic             marked;
  logic [1:0]       run_len;
  logic [2:0]       total;
  logic             final_word;
  logic             load;
  logic [WordW-1:0] sel_word;

  assign marked  = cmd.run_count > RunMinMarked;
  assign run_len = marked ? 2'd3 : cmd.run_count[1:0];
  assign total   = {1'b0, run_len} + {2'b00, cmd.has_extra};

  assign final_word = (({1'b0, phase_r} + 3'd1) == total);
  assign load       = cmd_valid && (!out_valid_r || out_tready);
  assign pop        = load && final_word;

  always_comb begin
    if (phase_r < run_len) begin
      if (marked && phase_r == 2'd0) begin
        sel_word = RunMarker;
      end else if (marked && phase_r == 2'd1) begin
        sel_word = cmd.run_count;
      end else begin
        sel_word = cmd.run_word;
      end
    end else begin
      sel_word = cmd.extra_word;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      phase_nxt     = final_word ? 2'd0 : phase_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= sel_word;
      out_user_r <= final_word;
      out_last_r <= final_word && cmd.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: rtl/word_run_length_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_run_length_encoder: run-length encoder for a stream of 64-bit words
// Repeats of a word are counted and sent as marker, count, word (or as plain
// copies for short runs); other words pass as literals.
// ----------------------------------------------------------------------------
// Input words are taken at one word per cycle while the command queue
// (QUEUE_DEPTH entries) has room; the front end needs no more than one compare
// and one increment per word. The back end sends one output word per cycle
// while out_tready does not stall it; an item causes 0 to 4 output words (a
// flushed run of up to three words plus a literal). Equal words in the middle
// of a run cause no output word. A literal stream runs at one word per cycle
// in and out while not stalled; the queue absorbs the bursts of a run flush.
module word_run_length_encoder
  import wrle_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] word
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] out_word
  output logic        out_tuser,  // [0] item_done
  output logic        out_tlast
);

  logic      q_full;
  logic      q_empty;
  logic      q_push;
  logic      q_pop;
  wrle_cmd_t q_in;
  wrle_cmd_t q_head;
  logic      in_xfer;

  assign in_tready = !q_full;
  assign in_xfer   = in_tvalid && in_tready;

  wrle_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_xfer),
    .word   (in_tdata),
    .last   (in_tlast),
    .push   (q_push),
    .cmd    (q_in)
  );

  wrle_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  wrle_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (!q_empty),
    .cmd        (q_head),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: rtl/wrle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrle_checker: port-level checks of the word run-length encoder
// Watches the top-level ports over time; bound to every instance.
// ----------------------------------------------------------------------------
module wrle_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // A stalled result transfer keeps its word and flags
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("wrle: stalled output changed");

  // Stream end is always the final word of its item
  a_last_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("wrle: stream end without item end");

  // Reset empties the output stage
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("wrle: output valid after reset");

endmodule

bind word_run_length_encoder wrle_checker u_wrle_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
